>>> src/inverted_blur_5x5_rgb_defines.svh
// Assertion helpers used by the RTL that checks itself.
`ifndef INVERTED_BLUR_5X5_RGB_DEFINES_SVH
`define INVERTED_BLUR_5X5_RGB_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define IBR_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibr: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define IBR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibr: next-cycle check failed");

`endif

>>> src/ibr_pkg.sv
`default_nettype none

package ibr_pkg;

    localparam int PIX_W   = 8;
    localparam int KSIZE   = 5;
    localparam int LB_ROWS = KSIZE - 1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam int FRAME_WIDTH_W      = 11;
    localparam int FRAME_HEIGHT_W     = 13;
    localparam int FRAME_WIDTH_RESET  = 1024;
    localparam int FRAME_HEIGHT_RESET = 768;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] chan_blue;
        logic [PIX_W-1:0] chan_green;
        logic [PIX_W-1:0] chan_red;
        logic             drain;
    } ibr_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_red;
        logic             frame_last;
    } ibr_out_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } ibr_pix_t;

    // element j of a column holds the pixel (KSIZE-1-j) rows above the newest
    typedef ibr_pix_t [KSIZE-1:0]   ibr_col_t;
    typedef ibr_pix_t [LB_ROWS-1:0] ibr_line_t;

    typedef struct packed {
        ibr_pix_t [KSIZE-1:0][KSIZE-1:0] taps;    // [dy + 2][dx + 2]
        logic     [KSIZE-1:0]            row_ok;
        logic     [KSIZE-1:0]            col_ok;
        logic                            last;
    } ibr_entry_t;

endpackage

`default_nettype wire

>>> src/ibr_front.sv
`default_nettype none

module ibr_front #(
    parameter int MAX_WIDTH,
    parameter int MAX_HEIGHT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ibr_pkg::ibr_in_t                    s_data,
    input  logic                                cfg_we,
    input  logic [ibr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ibr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [ibr_pkg::QUEUE_LEVEL_W-1:0]   q_level,
    output logic                                q_push,
    output ibr_pkg::ibr_entry_t                 q_entry
);
    import ibr_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int WW1  = WW + 1;
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int HW1  = HW + 1;
    localparam int OHW  = $clog2(MAX_HEIGHT);
    localparam int LW   = $clog2(2 * MAX_WIDTH + 3);
    localparam int QLW1 = QUEUE_LEVEL_W + 1;
    localparam int WIDTH_RESET  =
        (FRAME_WIDTH_RESET < MAX_WIDTH) ? FRAME_WIDTH_RESET : MAX_WIDTH;
    localparam int HEIGHT_RESET =
        (FRAME_HEIGHT_RESET < MAX_HEIGHT) ? FRAME_HEIGHT_RESET : MAX_HEIGHT;

    logic [WW-1:0]  w_reg, w_next;
    logic [HW-1:0]  h_reg, h_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [HW-1:0]  row_reg, row_next;
    logic [LW-1:0]  lag_reg, lag_next;
    logic [CW-1:0]  ocol_reg, ocol_next;
    logic [OHW-1:0] orow_reg, orow_next;

    logic             a_valid_reg;
    logic             a_emit_reg;
    logic             a_last_reg;
    logic [KSIZE-1:0] a_rok_reg;
    logic [KSIZE-1:0] a_cok_reg;
    ibr_pix_t         a_pix_reg;
    logic [CW-1:0]    a_addr_reg;

    ibr_line_t line_mem [MAX_WIDTH];
    ibr_line_t rd_data_reg;
    logic      fwd_hit_reg;
    ibr_line_t fwd_data_reg;

    ibr_col_t  win_reg  [KSIZE];
    ibr_col_t  win_next [KSIZE];

    logic [31:0]      fw32, fh32;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic             in_frame, take, emit, clear;
    logic             col_wrap, ocol_wrap, out_last;
    logic [LW-1:0]    lag_val;
    logic [KSIZE-1:0] rok, cok;
    ibr_pix_t         in_pix;
    ibr_line_t        old_line, line_wr;
    ibr_col_t         new_col;

    always_comb begin
        fw32 = 32'(cfg_wdata[FRAME_WIDTH_W-1:0]);
        fh32 = 32'(cfg_wdata[FRAME_HEIGHT_W-1:0]);
        if (fw32 == 32'd0) begin
            w_eff = WW'(1);
        end else if (fw32 > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(fw32);
        end
        if (fh32 == 32'd0) begin
            h_eff = HW'(1);
        end else if (fh32 > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(fh32);
        end
    end

    assign s_ready = ({1'b0, q_level} + QLW1'(a_valid_reg)) < QLW1'(QUEUE_DEPTH);

    assign in_frame  = row_reg < h_reg;
    assign take      = s_valid && s_ready && !(in_frame && s_data.drain);
    assign lag_val   = (LW'(w_reg) << 1) + LW'(2);
    assign emit      = lag_reg == lag_val;
    assign col_wrap  = WW'(col_reg) == (w_reg - WW'(1));
    assign ocol_wrap = WW'(ocol_reg) == (w_reg - WW'(1));
    assign out_last  = ocol_wrap && (HW'(orow_reg) == (h_reg - HW'(1)));

    assign rok[0] = orow_reg >= OHW'(2);
    assign rok[1] = orow_reg != '0;
    assign rok[2] = 1'b1;
    assign rok[3] = (HW1'(orow_reg) + HW1'(1)) < HW1'(h_reg);
    assign rok[4] = (HW1'(orow_reg) + HW1'(2)) < HW1'(h_reg);
    assign cok[0] = ocol_reg >= CW'(2);
    assign cok[1] = ocol_reg != '0;
    assign cok[2] = 1'b1;
    assign cok[3] = (WW1'(ocol_reg) + WW1'(1)) < WW1'(w_reg);
    assign cok[4] = (WW1'(ocol_reg) + WW1'(2)) < WW1'(w_reg);

    assign in_pix.blue  = s_data.chan_blue;
    assign in_pix.green = s_data.chan_green;
    assign in_pix.red   = s_data.chan_red;

    always_comb begin
        w_next    = w_reg;
        h_next    = h_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        lag_next  = lag_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        clear     = 1'b0;
        if (cfg_we) begin
            if (cfg_index == CFG_FRAME_WIDTH) begin
                w_next = w_eff;
                clear  = 1'b1;
            end else if (cfg_index == CFG_FRAME_HEIGHT) begin
                h_next = h_eff;
                clear  = 1'b1;
            end
        end else if (take) begin
            if (col_wrap) begin
                col_next = '0;
                if (in_frame) begin
                    row_next = row_reg + HW'(1);
                end
            end else begin
                col_next = col_reg + CW'(1);
            end
            if (!emit) begin
                lag_next = lag_reg + LW'(1);
            end else if (out_last) begin
                clear = 1'b1;
            end else if (ocol_wrap) begin
                ocol_next = '0;
                orow_next = orow_reg + OHW'(1);
            end else begin
                ocol_next = ocol_reg + CW'(1);
            end
        end
        if (clear) begin
            col_next  = '0;
            row_next  = '0;
            lag_next  = '0;
            ocol_next = '0;
            orow_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg       <= WW'(WIDTH_RESET);
            h_reg       <= HW'(HEIGHT_RESET);
            col_reg     <= '0;
            row_reg     <= '0;
            lag_reg     <= '0;
            ocol_reg    <= '0;
            orow_reg    <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            lag_reg     <= lag_next;
            ocol_reg    <= ocol_next;
            orow_reg    <= orow_next;
            a_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            a_emit_reg   <= emit;
            a_last_reg   <= emit && out_last;
            a_rok_reg    <= rok;
            a_cok_reg    <= cok;
            a_pix_reg    <= in_pix;
            a_addr_reg   <= col_reg;
            fwd_hit_reg  <= a_valid_reg && (a_addr_reg == col_reg);
            fwd_data_reg <= line_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (a_valid_reg) begin
            line_mem[a_addr_reg] <= line_wr;
        end
    end

    always_comb begin
        old_line = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        for (int j = 0; j < LB_ROWS; j++) begin
            new_col[j] = old_line[j];
        end
        new_col[KSIZE-1] = a_pix_reg;
        for (int j = 0; j < LB_ROWS; j++) begin
            line_wr[j] = new_col[j+1];
        end
        for (int i = 0; i < KSIZE - 1; i++) begin
            win_next[i] = win_reg[i+1];
        end
        win_next[KSIZE-1] = new_col;
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg) begin
            win_reg <= win_next;
        end
    end

    assign q_push = a_valid_reg && a_emit_reg;

    always_comb begin
        for (int dy = 0; dy < KSIZE; dy++) begin
            for (int dx = 0; dx < KSIZE; dx++) begin
                q_entry.taps[dy][dx] = win_next[dx][dy];
            end
        end
        q_entry.row_ok = a_rok_reg;
        q_entry.col_ok = a_cok_reg;
        q_entry.last   = a_last_reg;
    end

endmodule

`default_nettype wire

>>> src/ibr_queue.sv
`default_nettype none

module ibr_queue (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  ibr_pkg::ibr_entry_t                push_entry,
    input  logic                               pop,
    output logic                               head_valid,
    output ibr_pkg::ibr_entry_t                head_entry,
    output logic [ibr_pkg::QUEUE_LEVEL_W-1:0]  level
);
    import ibr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    ibr_entry_t                 slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]              wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]              rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_LEVEL_W-1:0]   level_reg, level_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            level_next = level_reg + QUEUE_LEVEL_W'(1);
        end else if (pop && !push) begin
            level_next = level_reg - QUEUE_LEVEL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = level_reg != '0;
    assign head_entry = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

endmodule

`default_nettype wire

>>> src/ibr_back.sv
`default_nettype none

module ibr_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  ibr_pkg::ibr_entry_t  head_entry,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ibr_pkg::ibr_out_t    m_data
);
    import ibr_pkg::*;

    localparam int CHANNELS    = 3;
    localparam int ROW_SUM_W   = 12;
    localparam int SUM_W       = 14;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [SUM_W-1:0]   CEIL_BIAS  = 14'd34;
    localparam logic [RECIP_W-1:0] RECIP_35   = 15'd29960;
    localparam logic [PIX_W-1:0]   FULL_SCALE = 8'd255;

    function automatic logic [1:0] tap_weight(input int dy, input int dx);
        logic [1:0] wt;
        wt = 2'd1;
        if (dy >= 1 && dy <= 3 && dx >= 1 && dx <= 3) begin
            wt = 2'd2;
        end
        if (dy == 2 && dx == 2) begin
            wt = 2'd3;
        end
        return wt;
    endfunction

    function automatic logic [PIX_W-1:0] pix_chan(input ibr_pix_t p, input int ch);
        logic [PIX_W-1:0] v;
        case (ch)
            0: begin
                v = p.blue;
            end
            1: begin
                v = p.green;
            end
            default: begin
                v = p.red;
            end
        endcase
        return v;
    endfunction

    logic                   m_en, e_en, d_en, c_en;

    logic                   c_valid_reg, c_last_reg;
    logic [ROW_SUM_W-1:0]   c_rsum_reg  [CHANNELS][KSIZE];
    logic [ROW_SUM_W-1:0]   c_rsum_next [CHANNELS][KSIZE];

    logic                   d_valid_reg, d_last_reg;
    logic [SUM_W-1:0]       d_sum_reg  [CHANNELS];
    logic [SUM_W-1:0]       d_sum_next [CHANNELS];

    logic                   e_valid_reg, e_last_reg;
    logic [PROD_W-1:0]      e_prod_reg  [CHANNELS];
    logic [PROD_W-1:0]      e_prod_next [CHANNELS];

    logic                   m_valid_reg;
    ibr_out_t               m_data_reg, m_data_next;
    logic [PIX_W-1:0]       chan_out [CHANNELS];

    assign m_en = !m_valid_reg || m_ready;
    assign e_en = !e_valid_reg || m_en;
    assign d_en = !d_valid_reg || e_en;
    assign c_en = !c_valid_reg || d_en;
    assign pop  = c_en && head_valid;

    always_comb begin
        logic [ROW_SUM_W-1:0] acc;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            for (int dy = 0; dy < KSIZE; dy++) begin
                acc = '0;
                for (int dx = 0; dx < KSIZE; dx++) begin
                    if (head_entry.row_ok[dy] && head_entry.col_ok[dx]) begin
                        acc = acc + ROW_SUM_W'(tap_weight(dy, dx))
                            * ROW_SUM_W'(pix_chan(head_entry.taps[dy][dx], ch));
                    end
                end
                c_rsum_next[ch][dy] = acc;
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            d_sum_next[ch] = CEIL_BIAS;
            for (int dy = 0; dy < KSIZE; dy++) begin
                d_sum_next[ch] = d_sum_next[ch] + SUM_W'(c_rsum_reg[ch][dy]);
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            e_prod_next[ch] = PROD_W'(d_sum_reg[ch]) * PROD_W'(RECIP_35);
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            chan_out[ch] = FULL_SCALE - e_prod_reg[ch][RECIP_SHIFT +: PIX_W];
        end
        m_data_next.out_blue   = chan_out[0];
        m_data_next.out_green  = chan_out[1];
        m_data_next.out_red    = chan_out[2];
        m_data_next.frame_last = e_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (c_en) begin
                c_valid_reg <= head_valid;
            end
            if (d_en) begin
                d_valid_reg <= c_valid_reg;
            end
            if (e_en) begin
                e_valid_reg <= d_valid_reg;
            end
            if (m_en) begin
                m_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_en) begin
            c_rsum_reg <= c_rsum_next;
            c_last_reg <= head_entry.last;
        end
        if (d_en) begin
            d_sum_reg  <= d_sum_next;
            d_last_reg <= c_last_reg;
        end
        if (e_en) begin
            e_prod_reg <= e_prod_next;
            e_last_reg <= d_last_reg;
        end
        if (m_en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> src/inverted_blur_5x5_rgb.sv
// Channel  Handshake          Payload
// s_       s_valid / s_ready  ibr_in_t: chan_blue, chan_green, chan_red, drain
// m_       m_valid / m_ready  ibr_out_t: out_blue, out_green, out_red, frame_last
// cfg_     cfg_we             cfg_index, cfg_wdata (write only, no wait)
//
// One transaction per cycle per side unless stalled, set by the line store: one read and
// one write per pixel at the column address, with forwarding when consecutive pixels share
// a column. A pixel is queued in the cycle after acceptance; its result passes registers
// c, d, e and m. The result for pixel k follows the transaction 2*width+2 stream positions
// after it. Reset is synchronous; the line store is never cleared, edge taps are masked.
// s_ready drops once queued entries plus the pixel in the line-store stage reach 4.
`default_nettype none
`include "inverted_blur_5x5_rgb_defines.svh"

module inverted_blur_5x5_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ibr_pkg::ibr_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ibr_pkg::ibr_out_t                m_data,
    input  logic                             cfg_we,
    input  logic [ibr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ibr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ibr_pkg::*;

    logic                       q_push;
    ibr_entry_t                 q_entry;
    logic                       q_pop;
    logic                       q_head_valid;
    ibr_entry_t                 q_head;
    logic [QUEUE_LEVEL_W-1:0]   q_level;

    ibr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_level   (q_level),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    ibr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .level      (q_level)
    );

    ibr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    `IBR_ASSERT_IMPLY(a_push_has_room, aclk, aresetn, q_push, q_level < QUEUE_LEVEL_W'(QUEUE_DEPTH))
    `IBR_ASSERT_IMPLY(a_pop_not_empty, aclk, aresetn, q_pop, q_level != '0)
    `IBR_ASSERT_NEXT(a_push_lands, aclk, aresetn, q_push, q_level != '0)

endmodule

`default_nettype wire
